// File: hdl/rma_pkg.sv
// Shared types and constants of the running mean accumulator.
package rma_pkg;

   localparam int SampleWidth    = 32;
   localparam int SumWidth       = 64;
   localparam int CountWidth     = 32;
   localparam int ReqDataWidth   = 40;
   localparam int RspDataWidth   = 72;
   localparam int QueueDepth     = 2;
   localparam int QueueAddrWidth = 1;
   localparam int QueueFillWidth = 2;
   localparam int StepWidth      = 5;

   localparam logic [CountWidth-1:0] CountFull = '1;
   localparam logic [StepWidth-1:0]  LastStep  = StepWidth'(CountWidth - 1);

   localparam logic StatusOk    = 1'b0;
   localparam logic StatusEmpty = 1'b1;

   typedef struct packed {
      logic [SumWidth-1:0]   sum;
      logic [CountWidth-1:0] count;
      logic                  refused;
   } snapshot_type;

   typedef struct packed {
      logic         valid;
      snapshot_type snap;
   } push_type;

   typedef struct packed {
      logic                      full;
      logic                      empty;
      logic [QueueFillWidth-1:0] fill;
   } queue_status_type;

   typedef enum logic [4:0] {
      BackIdle   = 5'b00001,
      BackPrep   = 5'b00010,
      BackDivide = 5'b00100,
      BackSign   = 5'b01000,
      BackDone   = 5'b10000
   } back_state_type;

endpackage

// File: hdl/rma_front.sv
// Front part: updates sum, count and refused flag per item and snapshots reports.
module rma_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              clear_first,
   input  logic                              sample_present,
   input  logic [rma_pkg::SampleWidth-1:0]   sample,
   input  logic                              report,
   output rma_pkg::push_type                 push
);

   logic [rma_pkg::SumWidth-1:0]   sum_ff, sum_in, sum_base;
   logic [rma_pkg::CountWidth-1:0] tally_ff, tally_in, tally_base;
   logic                           refused_ff, refused_in, refused_base;

   always_comb begin
      sum_base     = clear_first ? '0 : sum_ff;
      tally_base   = clear_first ? '0 : tally_ff;
      refused_base = clear_first ? 1'b0 : refused_ff;
      sum_in       = sum_base;
      tally_in     = tally_base;
      refused_in   = refused_base;
      if (sample_present) begin
         // A full count refuses the sample and leaves the sum alone.
         if (tally_base == rma_pkg::CountFull) begin
            refused_in = 1'b1;
         end else begin
            sum_in   = sum_base + {{(rma_pkg::SumWidth - rma_pkg::SampleWidth){sample[
                           rma_pkg::SampleWidth-1]}}, sample};
            tally_in = tally_base + rma_pkg::CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         tally_ff   <= '0;
         refused_ff <= 1'b0;
      end else if (accept) begin
         sum_ff     <= sum_in;
         tally_ff   <= tally_in;
         refused_ff <= refused_in;
      end
   end

   assign push.valid        = accept & report;
   assign push.snap.sum     = sum_in;
   assign push.snap.count   = tally_in;
   assign push.snap.refused = refused_in;

endmodule

// File: hdl/rma_queue.sv
// Short queue of report snapshots between the front and the divider.
module rma_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  rma_pkg::push_type          push,
   input  logic                       pop,
   output rma_pkg::snapshot_type      head,
   output rma_pkg::queue_status_type  status
);

   rma_pkg::snapshot_type entry_ff [rma_pkg::QueueDepth];
   logic [rma_pkg::QueueAddrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rma_pkg::QueueAddrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rma_pkg::QueueFillWidth-1:0] fill_ff, fill_in;
   logic                               do_push, do_pop;

   assign status.fill  = fill_ff;
   assign status.full  = (fill_ff == rma_pkg::QueueFillWidth'(rma_pkg::QueueDepth));
   assign status.empty = (fill_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push.valid & ~status.full;
   assign do_pop  = pop & ~status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rma_pkg::QueueAddrWidth'(rma_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + rma_pkg::QueueAddrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rma_pkg::QueueAddrWidth'(rma_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + rma_pkg::QueueAddrWidth'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + rma_pkg::QueueFillWidth'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - rma_pkg::QueueFillWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.snap;
      end
   end

endmodule

// File: hdl/rma_back.sv
// Back part: bit-serial rounded division of the sum by the count and the result register.
module rma_back (
   input  logic                                clock,
   input  logic                                reset,
   input  rma_pkg::snapshot_type               head,
   input  rma_pkg::queue_status_type           queue_status,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rma_pkg::RspDataWidth-1:0]    rsp_tdata
);

   rma_pkg::back_state_type state_ff, state_in;

   logic [rma_pkg::SumWidth-1:0]   sum_ff;
   logic [rma_pkg::CountWidth-1:0] count_ff;
   logic                           refused_ff;
   logic                           neg_ff, neg_in;
   logic [rma_pkg::CountWidth-1:0] rem_ff, rem_in;
   logic [rma_pkg::CountWidth-1:0] quot_ff, quot_in;
   logic [rma_pkg::StepWidth-1:0]  step_ff, step_in;
   logic [rma_pkg::SampleWidth-1:0] mean_ff, mean_in;
   logic                           status_ff, status_in;

   logic [rma_pkg::SumWidth-1:0]   dividend;
   logic [rma_pkg::CountWidth:0]   trial;
   logic [rma_pkg::CountWidth+1:0] diff;
   logic                           fits;

   // |sum| + count/2 as one add: a negative sum is inverted and the carry-in adds the one.
   assign dividend = (sum_ff[rma_pkg::SumWidth-1] ? ~sum_ff : sum_ff)
                   + rma_pkg::SumWidth'(count_ff >> 1)
                   + rma_pkg::SumWidth'(sum_ff[rma_pkg::SumWidth-1]);

   // The quotient fits in 32 bits, so the upper half of the dividend is already below the
   // count and only the lower 32 bits need a step each.
   assign trial = {rem_ff, quot_ff[rma_pkg::CountWidth-1]};
   assign diff  = {1'b0, trial} - {2'b00, count_ff};
   assign fits  = ~diff[rma_pkg::CountWidth+1];

   assign pop = (state_ff == rma_pkg::BackIdle) & ~queue_status.empty;

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      step_in   = step_ff;
      mean_in   = mean_ff;
      status_in = status_ff;
      case (state_ff)
         rma_pkg::BackIdle: begin
            if (!queue_status.empty) begin
               state_in = rma_pkg::BackPrep;
            end
         end
         rma_pkg::BackPrep: begin
            neg_in  = sum_ff[rma_pkg::SumWidth-1];
            rem_in  = dividend[rma_pkg::SumWidth-1:rma_pkg::CountWidth];
            quot_in = dividend[rma_pkg::CountWidth-1:0];
            step_in = '0;
            if (count_ff == '0) begin
               mean_in   = '0;
               status_in = rma_pkg::StatusEmpty;
               state_in  = rma_pkg::BackDone;
            end else begin
               state_in = rma_pkg::BackDivide;
            end
         end
         rma_pkg::BackDivide: begin
            rem_in  = fits ? diff[rma_pkg::CountWidth-1:0] : trial[rma_pkg::CountWidth-1:0];
            quot_in = {quot_ff[rma_pkg::CountWidth-2:0], fits};
            step_in = step_ff + rma_pkg::StepWidth'(1);
            if (step_ff == rma_pkg::LastStep) begin
               state_in = rma_pkg::BackSign;
            end
         end
         rma_pkg::BackSign: begin
            mean_in   = neg_ff ? (~quot_ff + rma_pkg::SampleWidth'(1)) : quot_ff;
            status_in = rma_pkg::StatusOk;
            state_in  = rma_pkg::BackDone;
         end
         rma_pkg::BackDone: begin
            if (rsp_tready) begin
               state_in = rma_pkg::BackIdle;
            end
         end
         default: begin
            state_in = rma_pkg::BackIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rma_pkg::BackIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         sum_ff     <= head.sum;
         count_ff   <= head.count;
         refused_ff <= head.refused;
      end
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      step_ff   <= step_in;
      mean_ff   <= mean_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = (state_ff == rma_pkg::BackDone);
   assign rsp_tdata  = {{(rma_pkg::RspDataWidth - rma_pkg::SampleWidth
                          - rma_pkg::CountWidth - 2){1'b0}},
                        refused_ff, status_ff, count_ff, mean_ff};

endmodule

// File: hdl/running_mean_accumulator.sv
// Running mean accumulator: sums signed samples and reports the rounded mean on request.
//
// Clearing and accumulation happen as an item is accepted, so samples stream in at one per
// cycle while the queue is not full. An item that asks for a report places a snapshot of
// sum, count and refused flag in a two-entry queue; the divider behind it takes one report
// at a time: it fetches the snapshot, forms |sum| + count/2, runs the one-bit-per-cycle
// restoring division, applies the sign and holds the result until it is handed over. Input is
// held off only while the queue holds two reports not yet taken into the divider. A report
// with no samples gives mean 0 and status 1, and skips the division.
module running_mean_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] clear_first, [1] sample_present, [33:2] sample, [34] report, [39:35] zero
   input  logic [rma_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] mean, [63:32] count, [64] status, [65] refused_seen, [71:66] zero
   output logic [rma_pkg::RspDataWidth-1:0]  rsp_tdata
);

   rma_pkg::push_type          push;
   rma_pkg::snapshot_type      head;
   rma_pkg::queue_status_type  queue_status;
   logic                       accept;
   logic                       pop;

   assign req_tready = ~queue_status.full;
   assign accept     = req_tvalid & req_tready;

   rma_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .clear_first    (req_tdata[0]),
      .sample_present (req_tdata[1]),
      .sample         (req_tdata[rma_pkg::SampleWidth+1:2]),
      .report         (req_tdata[rma_pkg::SampleWidth+2]),
      .push           (push)
   );

   rma_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (queue_status)
   );

   rma_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   // A report with no samples always carries a zero mean.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[31:0] == '0)
      else $error("empty report with nonzero mean");

   // An ok status is only given with a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[64] |-> rsp_tdata[63:32] != '0)
      else $error("ok report with zero count");

   // A snapshot is never pushed into a full queue, so the fill never passes its depth.
   assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !push.valid && queue_status.fill ==
         rma_pkg::QueueFillWidth'(rma_pkg::QueueDepth))
      else $error("report queue overrun");

   // The divider only fetches when a snapshot is waiting and no result waits to be taken.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty && !rsp_tvalid)
      else $error("fetch from empty queue or while a result waits");

endmodule

// File: verif/tb_running_mean_accumulator.sv
// Self-checking testbench for the running mean accumulator with a built-in mean predictor.
`timescale 1ns / 1ps

module tb_running_mean_accumulator;

   localparam int CycleLimit   = 1000000;
   localparam int ItemTarget   = 1750;
   localparam int DrainCycles  = 60;
   localparam int ReportLimit  = 10;

   typedef struct {
      logic signed [rma_pkg::SampleWidth-1:0] mean;
      logic [rma_pkg::CountWidth-1:0]         count;
      logic                                   status;
      logic                                   refused;
   } mean_report_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // [0] clear_first, [1] sample_present, [33:2] sample, [34] report, [39:35] zero
   logic [rma_pkg::ReqDataWidth-1:0]  req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // [31:0] mean, [63:32] count, [64] status, [65] refused_seen, [71:66] zero
   logic [rma_pkg::RspDataWidth-1:0]  rsp_tdata;

   // Predictor state.
   logic signed [rma_pkg::SumWidth-1:0] acc_sum = '0;
   logic [rma_pkg::CountWidth-1:0]      acc_count = '0;
   logic                                acc_refused = 1'b0;
   mean_report_type                     pending_reports[$];

   // Traffic shaping for both sides.
   int burst_max = 8;
   int gap_max   = 0;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_max = 0;
   int stall_left = 0;

   int cycle_count = 0;
   int mismatches = 0;
   int items_accepted = 0;
   int reports_checked = 0;
   logic [rma_pkg::CountWidth-1:0] peak_count = '0;

   running_mean_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("tb_running_mean_accumulator: FAIL");
         $finish;
      end
   end

   // Mean rounded half away from zero; the magnitude is formed in 65 bits so that
   // the most negative sum cannot wrap.
   function automatic logic signed [rma_pkg::SampleWidth-1:0] predict_mean(
      logic signed [rma_pkg::SumWidth-1:0] sum, logic [rma_pkg::CountWidth-1:0] n);
      logic [rma_pkg::SumWidth:0] mag;
      logic [rma_pkg::SumWidth:0] quotient;
      mag = sum[rma_pkg::SumWidth-1] ? ({1'b0, ~sum} + (rma_pkg::SumWidth + 1)'(1))
                                     : {1'b0, sum};
      quotient = (mag + (rma_pkg::SumWidth + 1)'(n / 2)) / (rma_pkg::SumWidth + 1)'(n);
      return sum[rma_pkg::SumWidth-1] ? -quotient[rma_pkg::SampleWidth-1:0]
                                      : quotient[rma_pkg::SampleWidth-1:0];
   endfunction

   function automatic void note_mismatch(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= ReportLimit)
         $display("mismatch at cycle %0d: %s expected %0d (0x%0h), got %0d (0x%0h)",
                  cycle_count, what, want, want, got, got);
   endfunction

   // Mirrors one accepted item into the predictor and queues the report it asks for.
   function automatic void account_item(logic clear_first, logic present,
                                        logic [rma_pkg::SampleWidth-1:0] value,
                                        logic report);
      mean_report_type want;
      if (clear_first) begin
         acc_sum = '0;
         acc_count = '0;
         acc_refused = 1'b0;
      end
      if (present) begin
         if (acc_count == rma_pkg::CountFull) begin
            acc_refused = 1'b1;
         end else begin
            acc_sum = acc_sum + {{(rma_pkg::SumWidth - rma_pkg::SampleWidth){
                                    value[rma_pkg::SampleWidth-1]}}, value};
            acc_count = acc_count + rma_pkg::CountWidth'(1);
         end
      end
      if (acc_count > peak_count)
         peak_count = acc_count;
      if (report) begin
         if (acc_count == '0) begin
            want.mean = '0;
            want.status = rma_pkg::StatusEmpty;
         end else begin
            want.mean = predict_mean(acc_sum, acc_count);
            want.status = rma_pkg::StatusOk;
         end
         want.count = acc_count;
         want.refused = acc_refused;
         pending_reports.push_back(want);
      end
   endfunction

   task automatic send_item(input logic clear_first, input logic present,
                            input logic [rma_pkg::SampleWidth-1:0] value, input logic report);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata <= rma_pkg::ReqDataWidth'({$urandom(), $urandom()});
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, report, value, present, clear_first};
      do @(posedge clock); while (!req_tready);
      items_accepted++;
      account_item(clear_first, present, value, report);
   endtask

   task automatic set_traffic(input int bursts, input int gaps, input int pct, input int stalls);
      burst_max = bursts;
      gap_max = gaps;
      stall_pct = pct;
      stall_max = stalls;
   endtask

   // The receiver either takes every result or stalls for random stretches.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, stall_max);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      mean_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            note_mismatch("unexpected result, mean", 0, $signed(rsp_tdata[31:0]));
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_tdata[31:0] !== want.mean)
               note_mismatch("mean", want.mean, $signed(rsp_tdata[31:0]));
            if (rsp_tdata[63:32] !== want.count)
               note_mismatch("count", want.count, rsp_tdata[63:32]);
            if (rsp_tdata[64] !== want.status)
               note_mismatch("status", want.status, rsp_tdata[64]);
            if (rsp_tdata[65] !== want.refused)
               note_mismatch("refused_seen", want.refused, rsp_tdata[65]);
         end
      end
   end

   function automatic logic [rma_pkg::SampleWidth-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         3: return 32'h8000_0000 + $urandom_range(0, 3);
         4, 5: return $urandom_range(0, 16) - 8;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_empty_reports();
      // A report straight after reset, after a clear, and a clear that carries a sample.
      send_item(1'b0, 1'b0, 32'h0, 1'b1);
      send_item(1'b1, 1'b0, 32'hDEAD_BEEF, 1'b1);
      send_item(1'b1, 1'b1, 32'd5, 1'b1);
      send_item(1'b1, 1'b0, 32'h0, 1'b1);
   endtask

   task automatic test_extreme_samples();
      send_item(1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1);
      send_item(1'b0, 1'b1, 32'h8000_0000, 1'b1);
      send_item(1'b1, 1'b1, 32'h8000_0000, 1'b1);
      send_item(1'b0, 1'b1, 32'h8000_0000, 1'b1);
      send_item(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_item(1'b1, 1'b1, 32'h0, 1'b1);
   endtask

   task automatic test_rounding_ties();
      // Exact halves must round away from zero on both signs.
      send_item(1'b1, 1'b1, 32'd1, 1'b0);
      send_item(1'b0, 1'b1, 32'd2, 1'b1);
      send_item(1'b1, 1'b1, -32'sd1, 1'b0);
      send_item(1'b0, 1'b1, -32'sd2, 1'b1);
      send_item(1'b1, 1'b1, 32'd1, 1'b0);
      send_item(1'b0, 1'b1, 32'd0, 1'b0);
      send_item(1'b0, 1'b1, 32'd0, 1'b1);
      send_item(1'b0, 1'b1, 32'd1, 1'b1);
   endtask

   task automatic test_ignored_samples();
      // The sample field carries garbage while no sample is present.
      send_item(1'b1, 1'b1, 32'd7, 1'b0);
      send_item(1'b0, 1'b0, 32'h8000_0000, 1'b1);
      send_item(1'b0, 1'b0, 32'h7FFF_FFFF, 1'b0);
      send_item(1'b0, 1'b1, 32'd8, 1'b1);
   endtask

   // The count-full refusal needs 2^32 - 1 samples first, which no bounded run can
   // feed, so refused_seen is only checked at zero here.
   task automatic test_random_streams();
      int effective;
      int run_len;
      logic clear_first;
      logic present;
      logic report;
      effective = 0;
      while (effective < ItemTarget) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: set_traffic(64, 0, 0, 0);
               1: set_traffic($urandom_range(1, 12), $urandom_range(1, 6), 30, 4);
               2: set_traffic($urandom_range(1, 4), 20, 5, 40);
               default: set_traffic($urandom_range(2, 20), 3, 50, 2);
            endcase
         end
         if ($urandom_range(0, 9) < 8) begin
            run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 250)
                                                   : $urandom_range(1, 16);
            for (int i = 0; i < run_len; i++) begin
               clear_first = (i == 0);
               present = (i == 0) ? ($urandom_range(0, 7) != 0) : 1'b1;
               report = (i == run_len - 1) || ($urandom_range(0, 5) == 0);
               send_item(clear_first, present, draw_sample(), report);
               effective++;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               clear_first = ($urandom_range(0, 3) == 0);
               present = ($urandom_range(0, 1) != 0);
               report = ($urandom_range(0, 1) != 0);
               send_item(clear_first, present, $urandom(), report);
               if (clear_first || present || report)
                  effective++;
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_traffic(4, 2, 20, 3);
      test_empty_reports();
      test_extreme_samples();
      set_traffic(64, 0, 0, 0);
      test_rounding_ties();
      set_traffic(2, 8, 40, 50);
      test_ignored_samples();
      test_random_streams();

      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Accepted %0d items and checked %0d mean reports; largest count %0d.",
               items_accepted, reports_checked, peak_count);
      $display("Covered empty reports, extreme samples, rounding ties and random runs.");
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("tb_running_mean_accumulator: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_running_mean_accumulator: FAIL");
      end
      $finish;
   end

endmodule

// File: running_mean_accumulator.f
hdl/rma_pkg.sv
hdl/rma_front.sv
hdl/rma_queue.sv
hdl/rma_back.sv
hdl/running_mean_accumulator.sv
verif/tb_running_mean_accumulator.sv
